FILE: hw/rtl/lrs_pkg.sv
// Shared types, constants and codes for the linear interpolation resampler.
`default_nettype none

package lrs_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 12;
   localparam int MAX_RUN     = 64;
   localparam int RUN_W       = $clog2(MAX_RUN);
   localparam int SKIP_W      = 9;
   localparam int SKIP_MAX    = 511;
   localparam int STEP_W      = 20;
   localparam int START_W     = 12;
   localparam int LIMIT_W     = 16;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd4096;
   localparam logic [START_W-1:0] START_RESET = 12'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd65535;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_INCREMENT = 2'd0,
      CSR_START_PHASE    = 2'd1,
      CSR_OUTPUT_LIMIT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] in_sample;
      logic                          first;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          last_of_run;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic skip;
      logic pass;
      logic start;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic primed;
      logic skip_pending;
      logic limit_hit;
      logic out_free;
      logic run_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lrs_ctrl.sv
// Controller state machine of the resampler: classifies each input and paces the output run.
`default_nettype none

module lrs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_first,
   output logic                    req_ready,
   input  wire lrs_pkg::status_type status,
   output lrs_pkg::cmd_type        cmd
);

   lrs_pkg::state_type state_ff;
   lrs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         lrs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_first || !status.primed) begin
                  cmd.load = 1'b1;
               end else if (status.skip_pending) begin
                  cmd.skip = 1'b1;
               end else if (status.limit_hit) begin
                  cmd.pass = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = lrs_pkg::ST_RUN;
               end
            end
         end
         lrs_pkg::ST_RUN: begin
            // One result per cycle while the output register can take it.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.run_last) begin
                  state_in = lrs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lrs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lrs_datapath.sv
// Datapath of the resampler: registers, phase accumulator, interpolator and output register.
`default_nettype none

module lrs_datapath #(
   parameter int FRAC_BITS = lrs_pkg::FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lrs_pkg::req_type                  req_data,
   input  wire logic                              csr_valid,
   input  wire logic [lrs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lrs_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire lrs_pkg::cmd_type                  cmd,
   output lrs_pkg::status_type                    status,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output lrs_pkg::rsp_type                       rsp_data
);

   localparam int S      = lrs_pkg::SAMPLE_BITS;
   localparam int PROD_W = S + FRAC_BITS + 2;
   localparam int SUM_W  = FRAC_BITS + lrs_pkg::STEP_W + 1;
   localparam int CAR_W  = SUM_W - FRAC_BITS;
   localparam int EXT_W  = FRAC_BITS + lrs_pkg::START_W;

   logic [lrs_pkg::STEP_W-1:0]   step_ff;
   logic [lrs_pkg::START_W-1:0]  start_ff;
   logic [lrs_pkg::LIMIT_W-1:0]  limit_ff;
   logic [FRAC_BITS-1:0]         phase_ff, phase_in;
   logic [lrs_pkg::SKIP_W-1:0]   skip_ff, skip_in;
   logic [lrs_pkg::LIMIT_W-1:0]  produced_ff, produced_in;
   logic                         primed_ff, primed_in;
   logic [lrs_pkg::RUN_W-1:0]    run_cnt_ff, run_cnt_in;
   logic signed [S-1:0]          prev_ff, prev_in;
   logic signed [S-1:0]          cur_ff, cur_in;
   logic signed [S:0]            diff_ff, diff_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lrs_pkg::rsp_type             rsp_ff, rsp_in;

   logic [EXT_W-1:0]             start_ext;
   logic [SUM_W-1:0]             sum;
   logic [CAR_W-1:0]             carry;
   logic [CAR_W-1:0]             skip_new;
   logic signed [PROD_W-1:0]     prod;
   logic signed [PROD_W-1:0]     scaled;
   logic signed [S+1:0]          value;
   logic [lrs_pkg::LIMIT_W:0]    produced_next;
   logic                         last;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= lrs_pkg::STEP_RESET;
         start_ff <= lrs_pkg::START_RESET;
         limit_ff <= lrs_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (lrs_pkg::csr_index_type'(csr_index))
            lrs_pkg::CSR_STEP_INCREMENT: step_ff <= csr_data;
            lrs_pkg::CSR_START_PHASE:    start_ff <= csr_data[lrs_pkg::START_W-1:0];
            lrs_pkg::CSR_OUTPUT_LIMIT:   limit_ff <= csr_data[lrs_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      start_ext     = {{FRAC_BITS{1'b0}}, start_ff};
      sum           = SUM_W'(phase_ff) + SUM_W'(step_ff);
      carry         = sum[SUM_W-1:FRAC_BITS];
      skip_new      = carry - CAR_W'(1);
      prod          = PROD_W'(diff_ff) * $signed({{(PROD_W-FRAC_BITS){1'b0}}, phase_ff});
      // Arithmetic shift gives the floor of the scaled difference.
      scaled        = prod >>> FRAC_BITS;
      value         = (S+2)'(prev_ff) + scaled[S+1:0];
      produced_next = (lrs_pkg::LIMIT_W+1)'(produced_ff) + 1'b1;
      last          = (carry != '0)
                      || (run_cnt_ff == lrs_pkg::RUN_W'(lrs_pkg::MAX_RUN - 1))
                      || (produced_next == (lrs_pkg::LIMIT_W+1)'(limit_ff));
   end

   always_comb begin
      phase_in     = phase_ff;
      skip_in      = skip_ff;
      produced_in  = produced_ff;
      primed_in    = primed_ff;
      run_cnt_in   = run_cnt_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      diff_in      = diff_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         phase_in    = start_ext[FRAC_BITS-1:0];
         skip_in     = '0;
         produced_in = '0;
         primed_in   = 1'b1;
         prev_in     = req_data.in_sample;
      end
      if (cmd.skip) begin
         skip_in = skip_ff - 1'b1;
         prev_in = req_data.in_sample;
      end
      if (cmd.pass) begin
         prev_in = req_data.in_sample;
      end
      if (cmd.start) begin
         cur_in     = req_data.in_sample;
         diff_in    = (S+1)'(req_data.in_sample) - (S+1)'(prev_ff);
         run_cnt_in = '0;
      end
      if (cmd.emit) begin
         rsp_in.out_sample  = value[S-1:0];
         rsp_in.last_of_run = last;
         rsp_valid_in       = 1'b1;
         phase_in           = sum[FRAC_BITS-1:0];
         produced_in        = produced_next[lrs_pkg::LIMIT_W-1:0];
         run_cnt_in         = run_cnt_ff + 1'b1;
         if (carry != '0) begin
            skip_in = (skip_new > CAR_W'(lrs_pkg::SKIP_MAX))
                      ? lrs_pkg::SKIP_W'(lrs_pkg::SKIP_MAX)
                      : skip_new[lrs_pkg::SKIP_W-1:0];
         end
         if (last) begin
            prev_in = cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         skip_ff      <= '0;
         produced_ff  <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         produced_ff  <= produced_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_cnt_ff <= run_cnt_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      diff_ff    <= diff_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      status.primed       = primed_ff;
      status.skip_pending = (skip_ff != '0);
      status.limit_hit    = (produced_ff >= limit_ff);
      status.out_free     = !rsp_valid_ff || rsp_ready;
      status.run_last     = last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/linear_interp_resampler.sv
// Top level of the streaming linear interpolation resampler.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  lrs_pkg::req_type (in_sample, first)
//   rsp_      out        rsp_valid / rsp_ready  lrs_pkg::rsp_type (out_sample, last_of_run)
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data (always ready)
//
// An input is taken while the controller is idle; an input that produces N results
// then holds req_ready low while it makes them, one result per cycle through the shared
// multiplier of the datapath while rsp_ready does not stall the output register.
// The output register lets the next input be taken while the last result waits.
// Reset is synchronous and restores all registers but run count and the data registers.
`default_nettype none

module linear_interp_resampler #(
   parameter int FRAC_BITS = lrs_pkg::FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire lrs_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output lrs_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lrs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lrs_pkg::CSR_DATA_W-1:0]    csr_data
);

   lrs_pkg::cmd_type    cmd;
   lrs_pkg::status_type status;

   assign csr_ready = 1'b1;

   lrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_first (req_data.first),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrs_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/lrs_checker.sv
// Port-level checker for the resampler and its bind to the top level.
`default_nettype none

module lrs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire lrs_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire lrs_pkg::rsp_type rsp_data
);

   // A waiting result is neither dropped nor altered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped before its transfer");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // New results only come out of a run, during which no input is taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a run");

   // A first-marked input produces no run, so the block is ready again at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.first |=> req_ready)
      else $error("first-marked input started a run");

endmodule

bind linear_interp_resampler lrs_checker u_lrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: verif/linear_interp_resampler_tb.sv
// Self-checking testbench for the linear interpolation resampler with a predicting scoreboard.
module linear_interp_resampler_tb;
   import lrs_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int MAX_GAP         = 18;
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int TIMEOUT_CYCLES  = 2500000;

   class interp_scoreboard;
      logic [STEP_W-1:0]             step_increment;
      logic [START_W-1:0]            start_phase;
      logic [LIMIT_W-1:0]            output_limit;
      logic [FRAC_BITS-1:0]          phase;
      logic [SKIP_W-1:0]             skip_left;
      logic signed [SAMPLE_BITS-1:0] prev_sample;
      logic                          primed;
      logic [LIMIT_W-1:0]            produced;
      rsp_type                       expected_outputs[$];
      int                            failures;
      int                            outputs_seen;

      function new();
         step_increment = STEP_RESET;
         start_phase    = START_RESET;
         output_limit   = LIMIT_RESET;
         phase          = '0;
         skip_left      = '0;
         prev_sample    = '0;
         primed         = 1'b0;
         produced       = '0;
         failures       = 0;
         outputs_seen   = 0;
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_STEP_INCREMENT: step_increment = value[STEP_W-1:0];
            CSR_START_PHASE:    start_phase = value[START_W-1:0];
            CSR_OUTPUT_LIMIT:   output_limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // Works out the interpolated outputs that one accepted source sample causes.
      function void predict_outputs(req_type item);
         logic [STEP_W:0]           phase_sum;
         logic [STEP_W-FRAC_BITS:0] carry;
         longint                    delta;
         longint                    value;
         rsp_type                   entry;
         int                        count;
         count = 0;
         if (item.first || !primed) begin
            phase       = start_phase[FRAC_BITS-1:0];
            skip_left   = '0;
            produced    = '0;
            prev_sample = item.in_sample;
            primed      = 1'b1;
            return;
         end
         if (skip_left != 0) begin
            skip_left--;
            prev_sample = item.in_sample;
            return;
         end
         while (count < MAX_RUN && produced < output_limit) begin
            delta = longint'(item.in_sample) - longint'(prev_sample);
            // The arithmetic shift rounds toward minus infinity for negative slopes.
            value = longint'(prev_sample) + ((delta * longint'(phase)) >>> FRAC_BITS);
            phase_sum = phase + step_increment;
            carry = phase_sum[STEP_W:FRAC_BITS];
            entry.out_sample  = value[SAMPLE_BITS-1:0];
            entry.last_of_run = 1'b0;
            expected_outputs.push_back(entry);
            count++;
            produced++;
            phase = phase_sum[FRAC_BITS-1:0];
            if (carry != 0) begin
               skip_left = (carry - 1 > SKIP_MAX) ? SKIP_W'(SKIP_MAX) : SKIP_W'(carry - 1);
               break;
            end
         end
         if (count > 0) begin
            expected_outputs[expected_outputs.size()-1].last_of_run = 1'b1;
         end
         prev_sample = item.in_sample;
      endfunction

      function void check_output(rsp_type actual);
         rsp_type wanted;
         outputs_seen++;
         if (expected_outputs.size() == 0) begin
            $display("%0t unexpected output: expected none, actual sample %0d last %0b",
                     $time, actual.out_sample, actual.last_of_run);
            failures++;
            return;
         end
         wanted = expected_outputs.pop_front();
         if (actual.out_sample !== wanted.out_sample) begin
            $display("%0t out_sample mismatch: expected %0d, actual %0d",
                     $time, wanted.out_sample, actual.out_sample);
            failures++;
         end
         if (actual.last_of_run !== wanted.last_of_run) begin
            $display("%0t last_of_run mismatch: expected %0b, actual %0b",
                     $time, wanted.last_of_run, actual.last_of_run);
            failures++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   bit                         sender_burst = 1'b0;
   bit                         pressure_armed = 1'b0;
   bit                         pressure_done = 1'b0;

   interp_scoreboard interp_sb = new();

   linear_interp_resampler uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            interp_sb.check_output(rsp_data);
         end
         if (req_valid && req_ready) begin
            interp_sb.predict_outputs(req_data);
         end
         if (csr_valid && csr_ready) begin
            interp_sb.write_register(csr_index_type'(csr_index), csr_data);
         end
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return SAMPLE_BITS'($urandom_range(0, 64) - 32);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Offers one source sample and returns at the edge where its transfer happens.
   task automatic send_sample(input int sample, input logic is_first);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_sample: SAMPLE_BITS'(sample), first: is_first};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int step, input int start, input int limit);
      write_csr(CSR_STEP_INCREMENT, CSR_DATA_W'(step));
      write_csr(CSR_START_PHASE, CSR_DATA_W'(start));
      write_csr(CSR_OUTPUT_LIMIT, CSR_DATA_W'(limit));
   endtask

   // Waits for every predicted output, up to a drain limit, then lets a sample with no output finish too.
   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (interp_sb.pending() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int gap;
      int transfers;
      transfers = 0;
      forever begin
         if (pressure_armed && !pressure_done) begin
            gap = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
         end else if ((transfers / 50) % 2 == 1) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, MAX_GAP);
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_valid);
         transfers++;
      end
   end

   initial begin
      int phase_no;
      int step_value;
      int limit_value;
      int item_no;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: the opening sample has no first mark but must still prime.
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(32767, 1'b0);
      send_sample(0, 1'b1);
      send_sample(-1, 1'b0);
      wait_idle();

      // Upsampling from the highest start phase across full-scale swings.
      configure(1365, 4095, 65535);
      send_sample(-32768, 1'b1);
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(1, 1'b0);
      wait_idle();

      // Largest step: one output, then a long run of skipped samples.
      configure(1048575, 2048, 65535);
      send_sample(100, 1'b1);
      send_sample(-200, 1'b0);
      send_sample(5, 1'b0);
      send_sample(7, 1'b0);
      wait_idle();

      // A limit of one output; a new first mark starts a fresh count.
      configure(2048, 0, 1);
      send_sample(10, 1'b1);
      send_sample(20, 1'b0);
      send_sample(30, 1'b0);
      send_sample(40, 1'b1);
      send_sample(50, 1'b0);
      wait_idle();

      configure(4096, 0, 0);
      send_sample(1, 1'b1);
      send_sample(2, 1'b0);
      wait_idle();

      // A zero step never carries, so every run ends on the run cap.
      configure(0, 0, 65535);
      send_sample(1000, 1'b1);
      send_sample(-1000, 1'b0);
      send_sample(3000, 1'b0);
      wait_idle();

      configure(64, 0, 65535);
      send_sample(0, 1'b1);
      send_sample(32767, 1'b0);
      wait_idle();

      pressure_armed = 1'b1;
      phase_no = 0;
      while (phase_no < RANDOM_PHASES) begin
         case ($urandom_range(0, 5))
            0: step_value = 4096;
            1: step_value = $urandom_range(64, 1023);
            2: step_value = $urandom_range(1024, 4095);
            3: step_value = $urandom_range(4097, 16383);
            4: step_value = $urandom_range(16384, 262143);
            default: step_value = $urandom_range(0, 1048575);
         endcase
         case ($urandom_range(0, 2))
            0: limit_value = $urandom_range(1, 50);
            1: limit_value = $urandom_range(51, 65535);
            default: limit_value = 65535;
         endcase
         configure(step_value, $urandom_range(0, 4095), limit_value);
         sender_burst = (phase_no % 3 == 1);
         for (item_no = 0; item_no < ITEMS_PER_PHASE; item_no++) begin
            send_sample(random_sample(), item_no == 0 || $urandom_range(0, 24) == 0);
         end
         wait_idle();
         phase_no++;
      end

      if (interp_sb.pending() != 0) begin
         $display("%0t %0d expected outputs never arrived", $time, interp_sb.pending());
      end
      if (interp_sb.failures == 0 && interp_sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("status: fail");
      $finish;
   end

endmodule

FILE: linear_interp_resampler.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_ctrl.sv
hw/rtl/lrs_datapath.sv
hw/rtl/linear_interp_resampler.sv
hw/rtl/lrs_checker.sv
verif/linear_interp_resampler_tb.sv
